[src/sbfcn_pkg.sv]
// ----------------------------------------------------------------------------
// sbfcn_pkg
// Shared types and constants of the frame channel normalizer: frame layout,
// normalization constants, controller states and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package sbfcn_pkg;

	// frame layout
	localparam int NUM_CHANNELS = 16;
	localparam int FRAME_LEN    = 24;
	localparam int CH_BITS      = 11;
	localparam int DATA_BYTES   = 22;
	localparam int DATA_W       = DATA_BYTES * 8;
	localparam int CNT_W        = 5;
	localparam int IDX_W        = 4;
	localparam int LOST_BIT     = 2;

	localparam logic [7:0]       START_BYTE = 8'h0F;
	localparam logic [CNT_W-1:0] CNT_FLAG   = CNT_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(NUM_CHANNELS - 1);

	// normalization
	localparam logic [11:0] CENTER = 12'd1000;
	localparam logic [10:0] FLOOR  = 11'd400;
	localparam logic [10:0] SPAN   = 11'd600;
	localparam logic [15:0] ONE_Q14 = 16'sd16384;

	// |d| * 16384 / 600 == |d| * 2048 / 75 == (|d| * ceil(2^28/75)) >> 17
	localparam logic [31:0] RECIP_M  = 32'd3579140;
	localparam int          RECIP_SH = 17;

	typedef enum logic {
		S_RECV,
		S_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic             shift;  // data byte of the frame goes into the store
		logic             issue;  // next channel enters the normalize pipe
		logic [IDX_W-1:0] idx;
		logic             last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic adv;  // normalize pipe moves this cycle
	} dp_status_t;

endpackage

[src/sbfcn_ctrl.sv]
// ----------------------------------------------------------------------------
// sbfcn_ctrl
// Frame controller: counts received bytes, checks the start and flag bytes,
// and sequences the sixteen channel issues into the datapath.
// ----------------------------------------------------------------------------
module sbfcn_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	input  sbfcn_pkg::dp_status_t status,
	output sbfcn_pkg::ctrl_cmd_t  cmd
);
	import sbfcn_pkg::*;

	ctrl_state_t      state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] ch_q;
	logic             in_fire;
	logic             frame_ok;

	assign in_fire  = in_valid && in_ready;
	// flag byte arrives as the 24th beat; emit only when frame-lost is clear
	assign frame_ok = in_fire && (cnt_q == CNT_FLAG) && !rx_byte[LOST_BIT];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_RECV: begin
				if (frame_ok)
					state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (status.adv && ch_q == IDX_LAST)
					state_nxt = S_RECV;
			end
			default: state_nxt = S_RECV;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.shift = 1'b0;
		cmd.issue = 1'b0;
		cmd.idx   = ch_q;
		cmd.last  = (ch_q == IDX_LAST);
		case (state_q)
			S_RECV: begin
				in_ready  = 1'b1;
				cmd.shift = in_valid && cnt_q != '0 && cnt_q != CNT_FLAG;
			end
			S_EMIT: begin
				cmd.issue = status.adv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RECV;
			cnt_q   <= '0;
			ch_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_fire) begin
				if (cnt_q == '0)
					cnt_q <= (rx_byte == START_BYTE) ? CNT_W'(1) : '0;
				else if (cnt_q == CNT_FLAG)
					cnt_q <= '0;
				else
					cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.issue)
				ch_q <= cmd.last ? '0 : ch_q + IDX_W'(1);
		end
	end

	a_bad_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cnt_q == '0 && rx_byte != START_BYTE) |=> cnt_q == '0)
		else $error("wrong start byte did not hold the count at zero");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_EMIT && state_q == S_RECV) |-> ch_q == '0)
		else $error("channel counter not rewound after the frame");

	a_no_rx_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!cmd.shift && cnt_q == '0))
		else $error("channel issued while a frame is being collected");

endmodule

[src/sbfcn_dp.sv]
// ----------------------------------------------------------------------------
// sbfcn_dp
// Datapath: channel store as a byte shift line, deadband register, and a
// three-stage normalize pipe (clamp, reciprocal multiply, sign and output).
// ----------------------------------------------------------------------------
module sbfcn_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [9:0]                         deadband,
	input  logic [7:0]                         rx_byte,
	input  sbfcn_pkg::ctrl_cmd_t               cmd,
	output sbfcn_pkg::dp_status_t              status,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sbfcn_pkg::IDX_W-1:0]        channel_index,
	output logic signed [15:0]                 channel_value,
	output logic                               last
);
	import sbfcn_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [9:0]        deadband_q;
	logic              en;

	logic [10:0] raw;
	logic [11:0] raw_ext;
	logic        in_band;
	logic [10:0] g;
	logic [10:0] over;
	logic [9:0]  mag;

	logic             vld_s1, neg_s1, last_s1;
	logic [9:0]       mag_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s2, neg_s2, last_s2;
	logic [31:0]      prod_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [14:0]      q;

	logic             out_valid_q, last_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      value_q;

	assign en         = !out_valid_q || out_ready;
	assign status.adv = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			deadband_q <= '0;
		else if (cfg_valid)
			deadband_q <= deadband;
	end

	// bytes enter at the top; channel 0 sits at the bottom once the frame
	// is in, and each issue drops one channel off the bottom
	always_ff @(posedge clk) begin
		if (cmd.shift)
			data_q <= {rx_byte, data_q[DATA_W-1:8]};
		else if (cmd.issue)
			data_q <= data_q >> CH_BITS;
	end

	assign raw     = data_q[CH_BITS-1:0];
	assign raw_ext = {1'b0, raw};
	// band test written as v + t >= 1000 so a deadband above 1000 needs no sign
	assign in_band = (raw_ext + {2'b00, deadband_q} >= CENTER) &&
		(raw_ext <= CENTER + {2'b00, deadband_q});

	always_comb begin
		if (in_band)
			g = CENTER[10:0];
		else if (raw <= FLOOR)
			g = FLOOR;
		else
			g = raw;
		over = g - CENTER[10:0];
		if (g <= CENTER[10:0])
			mag = 10'(CENTER[10:0] - g);
		else if (over > SPAN)
			mag = SPAN[9:0];
		else
			mag = over[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= cmd.issue;
			vld_s2      <= vld_s1;
			out_valid_q <= vld_s2;
		end
	end

	assign q = prod_s2[RECIP_SH +: 15];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			neg_s1  <= (g > CENTER[10:0]);
			idx_s1  <= cmd.idx;
			last_s1 <= cmd.last;

			prod_s2 <= {22'b0, mag_s1} * RECIP_M;
			neg_s2  <= neg_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;

			value_q <= neg_s2 ? 16'(-{1'b0, q}) : {1'b0, q};
			idx_q   <= idx_s2;
			last_q  <= last_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_index = idx_q;
	assign channel_value = value_q;
	assign last          = last_q;

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (channel_value <= $signed(ONE_Q14) &&
			channel_value >= -$signed(ONE_Q14)))
		else $error("normalized value outside plus or minus one");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> idx_q == IDX_LAST)
		else $error("last marked on a channel other than the final one");

	a_pipe_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s2) |=> out_valid_q)
		else $error("pipe result lost on the way to the output register");

endmodule

[src/sbus_frame_channel_normalizer.sv]
// ----------------------------------------------------------------------------
// sbus_frame_channel_normalizer
// Collects 24-byte radio-control frames from serial bytes and emits the
// sixteen 11-bit channels of each good frame as signed Q1.14 stick values.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, rx_byte): one received byte per beat. A
// frame opens with 0x0F; a wrong first byte is dropped. The 24th byte is the
// flag byte; with frame-lost (bit 2) set the frame is discarded silently.
// Output channel (out_valid/out_ready): one beat per channel, index 0..15,
// last set on channel 15. Once the flag byte is accepted, the first channel
// passes the clamp, multiply and output registers before it is valid, then one
// result per cycle follows while out_ready is high; in_ready is low while the
// channels are issued, rising again once the last enters the normalize pipe.
// The pipe (clamp, 10x22 reciprocal multiply, sign) advances only when its
// output register is empty or taken, so a stalled receiver freezes the pipe
// and the channel issue with it; nothing is dropped.
// Config channel (cfg_valid/cfg_ready, deadband): always ready; write only
// while idle. Reset clears the byte count, the pipe and deadband to zero.
// ----------------------------------------------------------------------------
module sbus_frame_channel_normalizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [9:0]                  deadband,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sbfcn_pkg::IDX_W-1:0] channel_index,
	output logic signed [15:0]          channel_value,
	output logic                        last
);
	import sbfcn_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	sbfcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.status   (status),
		.cmd      (cmd)
	);

	sbfcn_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.deadband      (deadband),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last          (last)
	);

endmodule
